FILE: src/zcs_pkg.sv
// ----------------------------------------------------------------------------
// zcs_pkg
// Shared types and constants for the zero-crossing search block.
// ----------------------------------------------------------------------------
package zcs_pkg;

   localparam int MAX_FRAMES   = 16384;
   localparam int MAX_CHANNELS = 2;

   localparam int FRAME_W  = $clog2(MAX_FRAMES);
   localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ADDR_W   = CH_W + FRAME_W;
   localparam int SAMPLE_W = 16;

   // configuration port
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 15;
   localparam int CHAN_COUNT_W    = 2;
   localparam int FRAME_COUNT_W   = 15;
   localparam int FRAME_COUNT_RST = 16384;
   localparam int CHAN_COUNT_RST  = 1;

   // request fields
   localparam int REQ_CH_W    = 1;
   localparam int REQ_FRAME_W = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_FRAME_COUNT   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_PREV    = 2'd1,
      OP_NEXT    = 2'd2,
      OP_CLOSEST = 2'd3
   } opcode_type;

endpackage

FILE: src/zcs_req_if.sv
// ----------------------------------------------------------------------------
// zcs_req_if
// Request channel: sample writes and crossing queries.
// ----------------------------------------------------------------------------
interface zcs_req_if;
   logic                                valid;
   logic                                ready;
   zcs_pkg::opcode_type                 opcode;
   logic [zcs_pkg::REQ_CH_W-1:0]        channel;
   logic [zcs_pkg::REQ_FRAME_W-1:0]     frame;
   logic signed [zcs_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, opcode, channel, frame, sample, input ready);
   modport sink   (input valid, opcode, channel, frame, sample, output ready);
endinterface

FILE: src/zcs_rsp_if.sv
// ----------------------------------------------------------------------------
// zcs_rsp_if
// Response channel: frame of the crossing found.
// ----------------------------------------------------------------------------
interface zcs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [zcs_pkg::FRAME_W-1:0]     crossing_frame;

   modport source (output valid, crossing_frame, input ready);
   modport sink   (input valid, crossing_frame, output ready);
endinterface

FILE: src/zero_crossing_search_top.sv
// ----------------------------------------------------------------------------
// zero_crossing_search_top
// Multichannel zero-crossing search over a stored block of audio samples.
//
// Samples (signed 16 bit) live in one synchronous RAM addressed {channel,
// frame}. A write transfer stores one sample, so writes stream at one per
// cycle back to back while the sequencer is idle. A query transfer (previous,
// next or closest crossing) starts a sequencer that walks the RAM one frame
// per cycle through its single read port: for each channel in use it costs
// (k + 1) reads for a walk of k frames, at most one extra read for the
// neighbor frame, and a fold step that merges the channel into the running
// max (previous) or min (next). Closest runs the previous and then the next
// search, so it costs about twice as much. A start frame beyond the last
// frame in use answers without touching the RAM. The result is held in an
// output register; the block keeps taking write transfers while a result
// waits, but a new query is only finished once that register drains.
// Configuration is written through csr_* and must only change while idle.
// ----------------------------------------------------------------------------
module zero_crossing_search_top (
   input  logic                              clock,
   input  logic                              reset,
   zcs_req_if.sink                           req_if,
   zcs_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [zcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [zcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FW = zcs_pkg::FRAME_W;
   localparam int CW = zcs_pkg::CH_W;
   localparam int SW = zcs_pkg::SAMPLE_W;

   // one-hot sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,   // sample at f_ff arrives from RAM
      ST_NBR  = 5'b00100,   // neighbor sample arrives from RAM
      ST_ACC  = 5'b01000,   // fold channel result into best
      ST_FIN  = 5'b10000    // hand result to output register
   } state_type;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [zcs_pkg::CHAN_COUNT_W-1:0]  chan_count_ff;
   logic [zcs_pkg::FRAME_COUNT_W-1:0] frame_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff  <= zcs_pkg::CHAN_COUNT_W'(zcs_pkg::CHAN_COUNT_RST);
         frame_count_ff <= zcs_pkg::FRAME_COUNT_W'(zcs_pkg::FRAME_COUNT_RST);
      end else if (csr_we) begin
         case (csr_index)
            zcs_pkg::CSR_CHANNEL_COUNT:
               chan_count_ff  <= csr_wdata[zcs_pkg::CHAN_COUNT_W-1:0];
            zcs_pkg::CSR_FRAME_COUNT:
               frame_count_ff <= csr_wdata[zcs_pkg::FRAME_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated counts: last valid frame and last channel index in use
   logic [FW-1:0] n_last;
   logic [CW-1:0] last_ch;

   always_comb begin
      if (frame_count_ff == '0) begin
         n_last = '0;
      end else if (frame_count_ff > zcs_pkg::FRAME_COUNT_W'(zcs_pkg::MAX_FRAMES)) begin
         n_last = FW'(zcs_pkg::MAX_FRAMES - 1);
      end else begin
         n_last = FW'(frame_count_ff - zcs_pkg::FRAME_COUNT_W'(1));
      end
      if (chan_count_ff == '0) begin
         last_ch = '0;
      end else if (chan_count_ff >= zcs_pkg::CHAN_COUNT_W'(zcs_pkg::MAX_CHANNELS)) begin
         last_ch = CW'(zcs_pkg::MAX_CHANNELS - 1);
      end else begin
         last_ch = CW'(chan_count_ff - zcs_pkg::CHAN_COUNT_W'(1));
      end
   end

   // ------------------------------------------------------------------
   // sample store
   // ------------------------------------------------------------------
   logic                          wr_en;
   logic [zcs_pkg::ADDR_W-1:0]    wr_addr;
   logic                          rd_en;
   logic [CW-1:0]                 rd_ch;
   logic [FW-1:0]                 rd_frame;
   logic [SW-1:0]                 rd_data;

   zcs_ram #(
      .WIDTH (SW),
      .DEPTH (1 << zcs_pkg::ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.sample),
      .rd_en   (rd_en),
      .rd_addr ({rd_ch, rd_frame}),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   state_type           state_ff, state_in;
   zcs_pkg::opcode_type op_ff, op_in;
   logic [FW-1:0]       start_ff, start_in;
   logic [CW-1:0]       ch_ff, ch_in;
   logic [FW-1:0]       f_ff, f_in;
   logic                dir_next_ff, dir_next_in;  // 0: walk down, 1: walk up
   logic                first_ff, first_in;        // next RAM word is the start sample
   logic                moved_ff, moved_in;
   logic                s0neg_ff, s0neg_in;
   logic                s0zero_ff, s0zero_in;
   logic [SW-1:0]       nbr_ff, nbr_in;            // last sample walked over
   logic [SW-1:0]       cur_ff, cur_in;            // sample at stop frame
   logic [FW-1:0]       best_ff, best_in;
   logic [FW-1:0]       p_ff, p_in;                // previous result for closest
   logic [FW-1:0]       res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]       rsp_frame_ff, rsp_frame_in;

   logic req_xfer;
   logic rsp_load;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign wr_en        = req_xfer && (req_if.opcode == zcs_pkg::OP_WRITE);
   assign wr_addr      = {CW'(req_if.channel), FW'(req_if.frame)};

   // 17-bit magnitude so that the most negative sample compares correctly
   function automatic logic [SW:0] mag(input logic [SW-1:0] v);
      logic [SW:0] ext;
      ext = {v[SW-1], v};
      return v[SW-1] ? (~ext + (SW+1)'(1)) : ext;
   endfunction

   // walk helpers
   logic [FW-1:0] f_step, f_back;
   logic          at_walk_edge, at_nbr_edge;
   logic          s0neg_now, s0zero_now, same_sign, keep_walking;
   logic          nbr_smaller, nbr_rd_smaller;
   logic [FW-1:0] best_fold;
   logic signed [FW:0] dist_p, dist_q;

   assign f_step       = dir_next_ff ? (f_ff + FW'(1)) : (f_ff - FW'(1));
   assign f_back       = dir_next_ff ? (f_ff - FW'(1)) : (f_ff + FW'(1));
   assign at_walk_edge = dir_next_ff ? (f_ff == n_last) : (f_ff == '0);
   assign at_nbr_edge  = dir_next_ff ? (f_ff == '0) : (f_ff == n_last);
   assign s0neg_now    = first_ff ? rd_data[SW-1] : s0neg_ff;
   assign s0zero_now   = first_ff ? (rd_data == '0) : s0zero_ff;
   assign same_sign    = !s0zero_now && (rd_data != '0) && (rd_data[SW-1] == s0neg_now);
   assign keep_walking = same_sign && !at_walk_edge;
   assign nbr_smaller    = mag(nbr_ff) < mag(rd_data);
   assign nbr_rd_smaller = mag(rd_data) < mag(cur_ff);

   // previous keeps the max over channels, next the min
   always_comb begin
      if (dir_next_ff) begin
         best_fold = (f_ff < best_ff) ? f_ff : best_ff;
      end else begin
         best_fold = (f_ff > best_ff) ? f_ff : best_ff;
      end
   end

   // closest: previous wins only when strictly nearer (either side may be off by one)
   assign dist_p = $signed({1'b0, start_ff}) - $signed({1'b0, p_ff});
   assign dist_q = $signed({1'b0, best_fold}) - $signed({1'b0, start_ff});

   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      start_in    = start_ff;
      ch_in       = ch_ff;
      f_in        = f_ff;
      dir_next_in = dir_next_ff;
      first_in    = first_ff;
      moved_in    = moved_ff;
      s0neg_in    = s0neg_ff;
      s0zero_in   = s0zero_ff;
      nbr_in      = nbr_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      p_in        = p_ff;
      res_in      = res_ff;
      rd_en       = 1'b0;
      rd_ch       = ch_ff;
      rd_frame    = f_ff;

      case (state_ff)
         ST_IDLE: begin
            // read of the start sample goes out with the query transfer
            rd_ch    = '0;
            rd_frame = FW'(req_if.frame);
            if (req_xfer && (req_if.opcode != zcs_pkg::OP_WRITE)) begin
               op_in       = req_if.opcode;
               start_in    = FW'(req_if.frame);
               ch_in       = '0;
               f_in        = FW'(req_if.frame);
               first_in    = 1'b1;
               moved_in    = 1'b0;
               dir_next_in = (req_if.opcode == zcs_pkg::OP_NEXT);
               best_in     = (req_if.opcode == zcs_pkg::OP_NEXT) ? n_last : '0;
               if (FW'(req_if.frame) > n_last) begin
                  res_in   = (req_if.opcode == zcs_pkg::OP_PREV) ? '0 : n_last;
                  state_in = ST_FIN;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            first_in = 1'b0;
            if (first_ff) begin
               s0neg_in  = s0neg_now;
               s0zero_in = s0zero_now;
            end
            if (keep_walking) begin
               nbr_in   = rd_data;
               moved_in = 1'b1;
               f_in     = f_step;
               rd_en    = 1'b1;
               rd_frame = f_step;
            end else begin
               cur_in = rd_data;
               if (moved_ff) begin
                  // neighbor already seen during the walk
                  f_in     = nbr_smaller ? f_back : f_ff;
                  state_in = ST_ACC;
               end else if (!at_nbr_edge) begin
                  rd_en    = 1'b1;
                  rd_frame = f_back;
                  state_in = ST_NBR;
               end else begin
                  state_in = ST_ACC;
               end
            end
         end

         ST_NBR: begin
            if (nbr_rd_smaller) begin
               f_in = f_back;
            end
            state_in = ST_ACC;
         end

         ST_ACC: begin
            best_in  = best_fold;
            first_in = 1'b1;
            moved_in = 1'b0;
            f_in     = start_ff;
            rd_frame = start_ff;
            if (ch_ff != last_ch) begin
               ch_in    = ch_ff + CW'(1);
               rd_ch    = ch_ff + CW'(1);
               rd_en    = 1'b1;
               state_in = ST_WALK;
            end else if ((op_ff == zcs_pkg::OP_CLOSEST) && !dir_next_ff) begin
               // previous pass done, start the next pass
               p_in        = best_fold;
               dir_next_in = 1'b1;
               best_in     = n_last;
               ch_in       = '0;
               rd_ch       = '0;
               rd_en       = 1'b1;
               state_in    = ST_WALK;
            end else begin
               if (op_ff == zcs_pkg::OP_CLOSEST) begin
                  res_in = (dist_p < dist_q) ? p_ff : best_fold;
               end else begin
                  res_in = best_fold;
               end
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: holds a result until the response transfer
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_frame_in = rsp_load ? res_ff : rsp_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      start_ff     <= start_in;
      ch_ff        <= ch_in;
      f_ff         <= f_in;
      dir_next_ff  <= dir_next_in;
      first_ff     <= first_in;
      moved_ff     <= moved_in;
      s0neg_ff     <= s0neg_in;
      s0zero_ff    <= s0zero_in;
      nbr_ff       <= nbr_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      p_ff         <= p_in;
      res_ff       <= res_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.crossing_frame = rsp_frame_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // the walk never leaves the frames in use
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) || (state_ff == ST_NBR) || (state_ff == ST_ACC))
         |-> (f_ff <= n_last))
      else $error("walk frame beyond frame_count");

   // a previous search ends at most one frame above its start
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACC) && !dir_next_ff)
         |-> ({1'b0, f_ff} <= ({1'b0, start_ff} + (FW+1)'(1))))
      else $error("previous search ended above start frame");

   // a new result only appears out of the finish state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response without finished query");

   // a delivered frame always lies in the frames in use
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_frame_ff <= n_last))
      else $error("response frame beyond frame_count");

endmodule

FILE: src/zcs_ram.sv
// ----------------------------------------------------------------------------
// zcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module zcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/zero_crossing_search_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_search_top_test
// Self-checking bench for the zero-crossing search block. Sample writes and
// crossing queries go in on the request channel. A local model of the sample
// store and the search rules computes each crossing frame. Every response
// transfer is checked against the oldest pending crossing, in order.
// ----------------------------------------------------------------------------
module zero_crossing_search_top_test;

   localparam int HALF_PERIOD   = 5;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int IDLE_PERCENT  = 31;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int REPORT_LIMIT  = 10;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_we    = 1'b0;
   zcs_pkg::csr_index_type         csr_index = zcs_pkg::CSR_CHANNEL_COUNT;
   logic [zcs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   zcs_req_if req_bus ();
   zcs_rsp_if rsp_bus ();

   zero_crossing_search_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the sample store. pcm_written tracks which entries have
   // been loaded, so that no query is ever sent that would read a blank one.
   logic signed [zcs_pkg::SAMPLE_W-1:0] pcm_store
      [zcs_pkg::MAX_CHANNELS][zcs_pkg::MAX_FRAMES];
   bit pcm_written [zcs_pkg::MAX_CHANNELS][zcs_pkg::MAX_FRAMES];
   logic [zcs_pkg::CHAN_COUNT_W-1:0]  chan_count_reg  =
      zcs_pkg::CHAN_COUNT_W'(zcs_pkg::CHAN_COUNT_RST);
   logic [zcs_pkg::FRAME_COUNT_W-1:0] frame_count_reg =
      zcs_pkg::FRAME_COUNT_W'(zcs_pkg::FRAME_COUNT_RST);
   bit                                touched_blank;

   // Crossing frames still owed by the block, oldest first.
   logic [zcs_pkg::FRAME_W-1:0] crossing_queue [$];
   logic [zcs_pkg::FRAME_W-1:0] expected_frame;

   int fail_count   = 0;
   int cycle_count  = 0;
   bit steady       = 1'b0;   // no idling on either side while set
   int hold_request = 0;      // long response hold-off, picked up by the sink
   int hold_left    = 0;

   // Waveform generator state: runs of one sign with random length.
   int run_left     = 0;
   bit run_positive = 1'b0;
   int max_run      = 4;

   always #HALF_PERIOD clock = ~clock;

   // -------------------------------------------------------------------------
   // Search model
   // -------------------------------------------------------------------------
   function automatic int pcm_at(int ch, int fr);
      if (!pcm_written[ch][fr]) touched_blank = 1'b1;
      return int'(pcm_store[ch][fr]);
   endfunction

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   // Register values outside the legal range saturate when used.
   function automatic int frames_in_use();
      if (frame_count_reg == 0) return 1;
      if (frame_count_reg > zcs_pkg::MAX_FRAMES) return zcs_pkg::MAX_FRAMES;
      return int'(frame_count_reg);
   endfunction

   function automatic int channels_in_use();
      if (chan_count_reg == 0) return 1;
      if (chan_count_reg > zcs_pkg::MAX_CHANNELS) return zcs_pkg::MAX_CHANNELS;
      return int'(chan_count_reg);
   endfunction

   // Walk down while the sign of the start sample holds, then settle on the
   // neighbor with the smaller magnitude (a tie keeps the lower frame).
   // The latest frame over all channels wins.
   function automatic int prev_crossing(int start);
      int n;
      int best;
      int ch;
      int f;
      int s0;
      n    = frames_in_use();
      best = 0;
      if (start >= n) return 0;
      for (ch = 0; ch < channels_in_use(); ch++) begin
         f  = start;
         s0 = pcm_at(ch, start);
         if (s0 > 0) begin
            while (f > 0 && pcm_at(ch, f) > 0) f--;
         end else if (s0 < 0) begin
            while (f > 0 && pcm_at(ch, f) < 0) f--;
         end
         if (f + 1 < n && magnitude(pcm_at(ch, f + 1)) < magnitude(pcm_at(ch, f))) f++;
         if (f > best) best = f;
      end
      return best;
   endfunction

   // Mirror image: walk up, a tie keeps the higher frame, the earliest frame
   // over all channels wins.
   function automatic int next_crossing(int start);
      int n;
      int best;
      int ch;
      int f;
      int s0;
      n    = frames_in_use();
      best = n - 1;
      if (start >= n) return best;
      for (ch = 0; ch < channels_in_use(); ch++) begin
         f  = start;
         s0 = pcm_at(ch, start);
         if (s0 > 0) begin
            while (f < n - 1 && pcm_at(ch, f) > 0) f++;
         end else if (s0 < 0) begin
            while (f < n - 1 && pcm_at(ch, f) < 0) f++;
         end
         if (f >= 1 && magnitude(pcm_at(ch, f - 1)) < magnitude(pcm_at(ch, f))) f--;
         if (f < best) best = f;
      end
      return best;
   endfunction

   function automatic int crossing_for(zcs_pkg::opcode_type op, int start);
      int p;
      int q;
      case (op)
         zcs_pkg::OP_PREV: return prev_crossing(start);
         zcs_pkg::OP_NEXT: return next_crossing(start);
         zcs_pkg::OP_CLOSEST: begin
            p = prev_crossing(start);
            q = next_crossing(start);
            // previous only if strictly nearer
            return (start - p < q - start) ? p : q;
         end
         default: return 0;
      endcase
   endfunction

   // True when the query reads only entries that were loaded.
   function automatic bit query_is_safe(zcs_pkg::opcode_type op, int start);
      touched_blank = 1'b0;
      void'(crossing_for(op, start));
      return !touched_blank;
   endfunction

   // Next sample of a signed waveform: sign runs of 1..max_run frames, with
   // zeros, full-scale values and small magnitudes (to provoke ties) mixed in.
   function automatic int wave_sample();
      int roll;
      int level;
      if (run_left == 0) begin
         run_positive = !run_positive;
         run_left     = $urandom_range(max_run, 1);
      end
      run_left--;
      roll = $urandom_range(99);
      if (roll < 6) return 0;
      if (roll < 12) level = run_positive ? 32767 : 32768;
      else if (roll < 40) level = $urandom_range(4, 1);
      else level = $urandom_range(32767, 1);
      return run_positive ? level : -level;
   endfunction

   function automatic void note_failure(string what, logic [zcs_pkg::FRAME_W-1:0] want,
                                        logic [zcs_pkg::FRAME_W-1:0] got);
      if (fail_count < REPORT_LIMIT)
         $display("[%0t] %s: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Offer one item at a falling edge, hold it until a transfer at a rising
   // edge, then update the model. valid stays high for a following item.
   task automatic send_item(zcs_pkg::opcode_type op, bit ch, int fr,
                            logic signed [zcs_pkg::SAMPLE_W-1:0] value);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.channel <= ch;
      req_bus.frame   <= zcs_pkg::REQ_FRAME_W'(fr);
      req_bus.sample  <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (op == zcs_pkg::OP_WRITE) begin
         pcm_store[ch][fr]   = value;
         pcm_written[ch][fr] = 1'b1;
      end else begin
         crossing_queue.push_back(zcs_pkg::FRAME_W'(crossing_for(op, fr)));
      end
   endtask

   // Channel and sample fields of a query are don't-care; randomize them.
   task automatic send_query(zcs_pkg::opcode_type op, int start);
      send_item(op, 1'($urandom), start, zcs_pkg::SAMPLE_W'($urandom));
   endtask

   // Drop valid and let the block go idle: all crossings in, plus a settling
   // wait for a trailing write.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (crossing_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_csr(zcs_pkg::csr_index_type idx, int value);
      settle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= zcs_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == zcs_pkg::CSR_CHANNEL_COUNT) chan_count_reg = zcs_pkg::CHAN_COUNT_W'(value);
      else frame_count_reg = zcs_pkg::FRAME_COUNT_W'(value);
   endtask

   // One randomized phase: program the registers, load frames lo..hi of both
   // channels with a waveform, then mix rewrites and queries. Queries that
   // would read a blank entry turn into writes. Starts beyond the frames in
   // use and writes above them are sprinkled in when the store allows it.
   task automatic run_phase(int chan_value, int frame_value, int lo, int hi,
                            int count, int run_limit, bit no_idle, int hold);
      int                  n;
      int                  ch;
      int                  fr;
      int                  roll;
      int                  start;
      zcs_pkg::opcode_type op;
      set_csr(zcs_pkg::CSR_CHANNEL_COUNT, chan_value);
      set_csr(zcs_pkg::CSR_FRAME_COUNT, frame_value);
      max_run = run_limit;
      steady  = no_idle;
      n       = frames_in_use();
      for (ch = 0; ch < zcs_pkg::MAX_CHANNELS; ch++)
         for (fr = lo; fr <= hi; fr++)
            send_item(zcs_pkg::OP_WRITE, ch[0], fr, zcs_pkg::SAMPLE_W'(wave_sample()));
      hold_request = hold;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            if (n < zcs_pkg::MAX_FRAMES && roll < 3)
               fr = $urandom_range(zcs_pkg::MAX_FRAMES - 1, n);
            else fr = $urandom_range(hi, lo);
            send_item(zcs_pkg::OP_WRITE, 1'($urandom), fr,
                      zcs_pkg::SAMPLE_W'(wave_sample()));
         end else begin
            op = zcs_pkg::opcode_type'($urandom_range(3, 1));
            if (n < zcs_pkg::MAX_FRAMES && $urandom_range(99) < 15)
               start = $urandom_range(zcs_pkg::MAX_FRAMES - 1, n);
            else
               start = $urandom_range(hi, lo);
            if (query_is_safe(op, start)) send_query(op, start);
            else send_item(zcs_pkg::OP_WRITE, 1'($urandom), $urandom_range(hi, lo),
                           zcs_pkg::SAMPLE_W'(wave_sample()));
         end
      end
      steady = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Reset values: one channel, full store. Only the top three frames are
   // loaded, so queries start at the top of the store.
   task automatic test_reset_defaults();
      zcs_pkg::opcode_type ops [3] = '{zcs_pkg::OP_PREV, zcs_pkg::OP_NEXT,
                                       zcs_pkg::OP_CLOSEST};
      int                  k;
      send_item(zcs_pkg::OP_WRITE, 1'b0, zcs_pkg::MAX_FRAMES - 3, 16'sd5);
      send_item(zcs_pkg::OP_WRITE, 1'b0, zcs_pkg::MAX_FRAMES - 2, -16'sd3);
      send_item(zcs_pkg::OP_WRITE, 1'b0, zcs_pkg::MAX_FRAMES - 1, 16'sd7);
      for (k = 0; k < 3; k++) begin
         send_query(ops[k], zcs_pkg::MAX_FRAMES - 1);
         send_query(ops[k], zcs_pkg::MAX_FRAMES - 2);
      end
   endtask

   // Hand-built eight-frame store on two channels: full-scale values, a zero
   // start sample, magnitude ties both ways, walks ending at frame 0 and at
   // the last frame, and start frames at and beyond the frames in use.
   task automatic test_directed_cases();
      int                  left_data  [8] = '{32767, 100, -5, -32768, 0, 3, 3, -3};
      int                  right_data [8] = '{-1, -2, 5, 5, -7, 1, 0, 32767};
      zcs_pkg::opcode_type ops    [11] = '{zcs_pkg::OP_PREV, zcs_pkg::OP_NEXT,
                                           zcs_pkg::OP_PREV, zcs_pkg::OP_NEXT,
                                           zcs_pkg::OP_CLOSEST, zcs_pkg::OP_PREV,
                                           zcs_pkg::OP_NEXT, zcs_pkg::OP_NEXT,
                                           zcs_pkg::OP_PREV, zcs_pkg::OP_NEXT,
                                           zcs_pkg::OP_CLOSEST};
      int                  starts [11] = '{0, 7, 3, 2, 5, 7, 5, 4, 8, 16383, 16383};
      int                  k;
      set_csr(zcs_pkg::CSR_CHANNEL_COUNT, 2);
      set_csr(zcs_pkg::CSR_FRAME_COUNT, 8);
      for (k = 0; k < 8; k++) begin
         send_item(zcs_pkg::OP_WRITE, 1'b0, k, zcs_pkg::SAMPLE_W'(left_data[k]));
         send_item(zcs_pkg::OP_WRITE, 1'b1, k, zcs_pkg::SAMPLE_W'(right_data[k]));
      end
      for (k = 0; k < 11; k++) send_query(ops[k], starts[k]);
   endtask

   // Register values outside the legal range: channel_count 0 and 3,
   // frame_count 0; both phases run on a one-frame store.
   task automatic test_register_limits();
      run_phase(0, 1, 0, 0, 12, 3, 1'b0, 0);
      run_phase(3, 0, 0, 0, 16, 2, 1'b0, 0);
   endtask

   // Back-to-back transfers, no idling on either side.
   task automatic test_streaming();
      run_phase(2, 24, 0, 23, 25, 6, 1'b1, 0);
   endtask

   // Long same-sign runs, so the walks go deep.
   task automatic test_long_runs();
      run_phase(1, 40, 0, 39, 25, 30, 1'b0, 0);
   endtask

   // Full store at the top end; junk in the upper data bits of the channel
   // register and all ones in the frame register.
   task automatic test_store_top();
      run_phase(15'h7FFE, 15'h7FFF, zcs_pkg::MAX_FRAMES - 30, zcs_pkg::MAX_FRAMES - 1,
                25, 6, 1'b0, 0);
   endtask

   // Sink holds off for a long stretch while requests keep coming, so the
   // result register fills and the request side stalls.
   task automatic test_output_backpressure();
      run_phase(2, 24, 0, 23, 25, 5, 1'b0, 400);
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // Check each response transfer against the oldest pending crossing.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (crossing_queue.size() == 0) begin
            note_failure("response with nothing pending", 'x, rsp_bus.crossing_frame);
         end else begin
            expected_frame = crossing_queue.pop_front();
            if (rsp_bus.crossing_frame !== expected_frame)
               note_failure("crossing_frame", expected_frame, rsp_bus.crossing_frame);
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.opcode  = zcs_pkg::OP_WRITE;
      req_bus.channel = '0;
      req_bus.frame   = '0;
      req_bus.sample  = '0;
      rsp_bus.ready   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_register_limits();
      test_streaming();
      test_long_runs();
      test_store_top();
      test_output_backpressure();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && crossing_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
